// ===== src/bb3_pkg.sv =====
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types, constants and small helpers of the 3x3 box blur.
// ----------------------------------------------------------------------------
package bb3_pkg;

   localparam int MAX_WIDTH_DEF    = 2048;
   localparam int MAX_HEIGHT_DEF   = 4096;
   localparam int FRAME_WIDTH_RST  = 640;
   localparam int FRAME_HEIGHT_RST = 480;

   localparam int CSR_INDEX_BITS  = 1;
   localparam int CSR_DATA_BITS   = 13;
   localparam int WIDTH_REG_BITS  = 12;
   localparam int HEIGHT_REG_BITS = 13;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 1'b1;

   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_DRAIN = 1'b1;

   localparam int LANES       = 3;
   localparam int SUM_BITS    = 10;
   localparam int TOTAL_BITS  = 12;
   localparam int NUMER_BITS  = 13;
   localparam int COUNT_BITS  = 4;
   localparam int RECIP_BITS  = 20;
   localparam int RECIP_SHIFT = 20;

   localparam logic [1:0] PHASE_LEFT   = 2'd0;
   localparam logic [1:0] PHASE_CENTER = 2'd1;
   localparam logic [1:0] PHASE_RIGHT  = 2'd2;
   localparam logic [1:0] PHASE_FLUSH  = 2'd3;

   typedef struct packed {
      logic       req_type;
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic       frame_last;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [SUM_BITS-1:0] red;
      logic [SUM_BITS-1:0] green;
      logic [SUM_BITS-1:0] blue;
   } lane_sum_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
      logic acc_clr;
      logic row_en;
   } lane_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SUM,
      ST_DIV
   } state_type;

   function automatic logic [1:0] next_slot(input logic [1:0] slot);
      logic [1:0] res;
      res = (slot == 2'd2) ? 2'd0 : slot + 2'd1;
      return res;
   endfunction

   function automatic logic [1:0] prev_slot(input logic [1:0] slot);
      logic [1:0] res;
      res = (slot == 2'd0) ? 2'd2 : slot - 2'd1;
      return res;
   endfunction

   function automatic logic [COUNT_BITS-1:0] tap_count(input logic up, input logic dn,
                                                       input logic lf, input logic rt);
      logic [COUNT_BITS-1:0] rows;
      logic [COUNT_BITS-1:0] cols;
      rows = COUNT_BITS'(1) + COUNT_BITS'(up) + COUNT_BITS'(dn);
      cols = COUNT_BITS'(1) + COUNT_BITS'(lf) + COUNT_BITS'(rt);
      return COUNT_BITS'(rows * cols);
   endfunction

   // ceil(2^20 / (2*count))
   function automatic logic [RECIP_BITS-1:0] recip_of(input logic [COUNT_BITS-1:0] count);
      logic [RECIP_BITS-1:0] res;
      case (count)
         4'd1:    res = 20'd524288;
         4'd2:    res = 20'd262144;
         4'd3:    res = 20'd174763;
         4'd4:    res = 20'd131072;
         4'd6:    res = 20'd87382;
         4'd9:    res = 20'd58255;
         default: res = '0;
      endcase
      return res;
   endfunction

endpackage

// ===== src/bb3_stream_if.sv =====
// ----------------------------------------------------------------------------
// bb3_stream_if
// Valid/ready channel carrying one payload struct per request.
// ----------------------------------------------------------------------------
interface bb3_stream_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

// ===== src/bb3_lane.sv =====
// ----------------------------------------------------------------------------
// bb3_lane
// One line store with its read register and a column accumulator.
// ----------------------------------------------------------------------------
module bb3_lane #(
   parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF,
   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bb3_pkg::lane_ctrl_type ctrl,
   input  logic [AW-1:0]          wr_addr,
   input  bb3_pkg::pixel_type     wr_data,
   input  logic [AW-1:0]          rd_addr,
   output bb3_pkg::lane_sum_type  lane_sum
);
   import bb3_pkg::*;

   pixel_type    line_mem [MAX_WIDTH];
   pixel_type    rd_data_ff;
   logic         rd_take_ff;
   lane_sum_type sum_ff;
   lane_sum_type sum_in;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= line_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_take_ff <= 1'b0;
      end else begin
         rd_take_ff <= ctrl.rd_en;
      end
   end

   always_comb begin
      sum_in = sum_ff;
      if (ctrl.acc_clr) begin
         sum_in = '0;
      end else if (rd_take_ff && ctrl.row_en) begin
         sum_in.red   = sum_ff.red   + SUM_BITS'(rd_data_ff.red);
         sum_in.green = sum_ff.green + SUM_BITS'(rd_data_ff.green);
         sum_in.blue  = sum_ff.blue  + SUM_BITS'(rd_data_ff.blue);
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   assign lane_sum = sum_ff;

endmodule

// ===== src/bb3_merge.sv =====
// ----------------------------------------------------------------------------
// bb3_merge
// Adds the lane sums and forms the rounded mean by reciprocal multiply.
// ----------------------------------------------------------------------------
module bb3_merge (
   input  logic                                clock,
   input  logic                                load,
   input  bb3_pkg::lane_sum_type               lane_sum [bb3_pkg::LANES],
   input  logic [bb3_pkg::COUNT_BITS-1:0]      count,
   output logic [7:0]                          mean_red,
   output logic [7:0]                          mean_green,
   output logic [7:0]                          mean_blue
);
   import bb3_pkg::*;

   localparam int PROD_BITS = NUMER_BITS + RECIP_BITS;

   logic [TOTAL_BITS-1:0] tot_red;
   logic [TOTAL_BITS-1:0] tot_green;
   logic [TOTAL_BITS-1:0] tot_blue;
   logic [NUMER_BITS-1:0] numer_red_ff, numer_red_in;
   logic [NUMER_BITS-1:0] numer_green_ff, numer_green_in;
   logic [NUMER_BITS-1:0] numer_blue_ff, numer_blue_in;
   logic [RECIP_BITS-1:0] recip_ff, recip_in;
   logic [PROD_BITS-1:0]  prod_red;
   logic [PROD_BITS-1:0]  prod_green;
   logic [PROD_BITS-1:0]  prod_blue;

   always_comb begin
      tot_red   = '0;
      tot_green = '0;
      tot_blue  = '0;
      for (int i = 0; i < LANES; i++) begin
         tot_red   = tot_red   + TOTAL_BITS'(lane_sum[i].red);
         tot_green = tot_green + TOTAL_BITS'(lane_sum[i].green);
         tot_blue  = tot_blue  + TOTAL_BITS'(lane_sum[i].blue);
      end
      numer_red_in   = {tot_red, 1'b0}   + NUMER_BITS'(count);
      numer_green_in = {tot_green, 1'b0} + NUMER_BITS'(count);
      numer_blue_in  = {tot_blue, 1'b0}  + NUMER_BITS'(count);
      recip_in       = recip_of(count);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         numer_red_ff   <= numer_red_in;
         numer_green_ff <= numer_green_in;
         numer_blue_ff  <= numer_blue_in;
         recip_ff       <= recip_in;
      end
   end

   assign prod_red   = PROD_BITS'(numer_red_ff)   * PROD_BITS'(recip_ff);
   assign prod_green = PROD_BITS'(numer_green_ff) * PROD_BITS'(recip_ff);
   assign prod_blue  = PROD_BITS'(numer_blue_ff)  * PROD_BITS'(recip_ff);

   assign mean_red   = prod_red[RECIP_SHIFT +: 8];
   assign mean_green = prod_green[RECIP_SHIFT +: 8];
   assign mean_blue  = prod_blue[RECIP_SHIFT +: 8];

endmodule

// ===== src/box_blur_3x3.sv =====
// ----------------------------------------------------------------------------
// box_blur_3x3
// 3x3 box blur over a raster-order RGB stream with in-frame neighbor counting.
//
// req_ch carries pixels (req_type pixel) followed by drain requests once the
// frame is in; rsp_ch returns blurred pixels in raster order, frame_last on
// the final one. Frame size is set through the csr write port, by the user only
// while idle (not enforced by the block); a write restarts the frame.
// A request that yields no pixel is done on acceptance; one that completes a
// neighborhood holds off further requests through three column reads via the
// single read port of each of the three line stores, a lane-merge stage and a
// reciprocal multiply; its result then enters the output register for rsp_ch.
// Reset sets the frame size to 640x480 and clears all positions; line store
// contents are not cleared, since only pixels of the running frame are read.
// When rsp_ch stalls, the output register holds its pixel and the next
// request is still accepted; a further result waits in the merge stage until
// the output register frees up.
// ----------------------------------------------------------------------------
module box_blur_3x3 #(
   parameter int MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   bb3_stream_if.sink                            req_ch,
   bb3_stream_if.source                          rsp_ch,
   input  logic                                  csr_write,
   input  logic [bb3_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [bb3_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   import bb3_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_HEIGHT + 1);
   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WIDTH_RST  = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;
   localparam int HEIGHT_RST = (FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RST;

   logic [CW-1:0] width_ff, width_in;
   logic [RW-1:0] height_ff, height_in;
   logic [CW-1:0] in_col_ff, in_col_in;
   logic [RW-1:0] in_row_ff, in_row_in;
   logic [1:0]    in_slot_ff, in_slot_in;
   logic [CW-1:0] out_col_ff, out_col_in;
   logic [RW-1:0] out_row_ff, out_row_in;
   logic [1:0]    out_slot_ff, out_slot_in;
   state_type     state_ff, state_in;
   logic [1:0]    phase_ff, phase_in;

   logic [CW-1:0] ctr_col_ff;
   logic [1:0]    ctr_slot_ff;
   logic          up_ff, dn_ff, lf_ff, rt_ff, last_ff;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic [31:0]   width_req;
   logic [31:0]   height_req;
   logic [CW-1:0] width_clamped;
   logic [RW-1:0] height_clamped;

   logic          accept;
   logic          inputs_done;
   logic          take_pixel;
   logic          live;
   logic [CW-1:0] post_col;
   logic [RW-1:0] post_row;
   logic [1:0]    post_slot;
   logic [CW-1:0] out_col_inc;
   logic [RW-1:0] out_row_inc;
   logic [CW-1:0] near_col;
   logic [RW-1:0] near_row;
   logic          due;
   logic          last_here;

   logic          req_ready;
   logic          rd_active;
   logic          merge_load;
   logic          out_load;
   logic          out_free;
   logic [CW-1:0] rd_col;
   pixel_type     wr_pixel;

   lane_ctrl_type lane_ctrl [LANES];
   lane_sum_type  lane_sum [LANES];
   logic [7:0]    mean_red, mean_green, mean_blue;

   // size clamping
   always_comb begin
      width_req  = 32'(csr_wdata[WIDTH_REG_BITS-1:0]);
      height_req = 32'(csr_wdata[HEIGHT_REG_BITS-1:0]);
      if (width_req == 32'd0) begin
         width_clamped = CW'(1);
      end else if (width_req > 32'(MAX_WIDTH)) begin
         width_clamped = CW'(MAX_WIDTH);
      end else begin
         width_clamped = CW'(width_req);
      end
      if (height_req == 32'd0) begin
         height_clamped = RW'(1);
      end else if (height_req > 32'(MAX_HEIGHT)) begin
         height_clamped = RW'(MAX_HEIGHT);
      end else begin
         height_clamped = RW'(height_req);
      end
   end

   // request decode and neighborhood readiness
   always_comb begin
      accept      = req_ch.valid && req_ready;
      inputs_done = in_row_ff >= height_ff;
      take_pixel  = accept && (req_ch.data.req_type == REQ_PIXEL) && !inputs_done;
      live        = take_pixel ||
                    (accept && (req_ch.data.req_type == REQ_DRAIN) && inputs_done);

      post_col  = in_col_ff;
      post_row  = in_row_ff;
      post_slot = in_slot_ff;
      if (take_pixel) begin
         if (in_col_ff + CW'(1) >= width_ff) begin
            post_col  = '0;
            post_row  = in_row_ff + RW'(1);
            post_slot = next_slot(in_slot_ff);
         end else begin
            post_col = in_col_ff + CW'(1);
         end
      end

      out_col_inc = out_col_ff + CW'(1);
      out_row_inc = out_row_ff + RW'(1);
      near_col    = (out_col_inc < width_ff) ? out_col_inc : width_ff - CW'(1);
      near_row    = (out_row_inc < height_ff) ? out_row_inc : height_ff - RW'(1);
      due         = live && ((post_row >= height_ff) || (post_row > near_row) ||
                             ((post_row == near_row) && (post_col > near_col)));
      last_here   = (out_row_ff == height_ff - RW'(1)) && (out_col_ff == width_ff - CW'(1));
   end

   // frame size and position counters
   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      in_col_in   = post_col;
      in_row_in   = post_row;
      in_slot_in  = post_slot;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      out_slot_in = out_slot_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  width_in  = width_clamped;
            CSR_FRAME_HEIGHT: height_in = height_clamped;
            default: ;
         endcase
         in_col_in   = '0;
         in_row_in   = '0;
         in_slot_in  = '0;
         out_col_in  = '0;
         out_row_in  = '0;
         out_slot_in = '0;
      end else if (due) begin
         if (last_here) begin
            in_col_in   = '0;
            in_row_in   = '0;
            in_slot_in  = '0;
            out_col_in  = '0;
            out_row_in  = '0;
            out_slot_in = '0;
         end else if (out_col_inc >= width_ff) begin
            out_col_in  = '0;
            out_row_in  = out_row_inc;
            out_slot_in = next_slot(out_slot_ff);
         end else begin
            out_col_in = out_col_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= CW'(WIDTH_RST);
         height_ff   <= RW'(HEIGHT_RST);
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_slot_ff  <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         out_slot_ff <= '0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         in_slot_ff  <= in_slot_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         out_slot_ff <= out_slot_in;
      end
   end

   // neighborhood of the pixel being computed
   always_ff @(posedge clock) begin
      if (due) begin
         ctr_col_ff  <= out_col_ff;
         ctr_slot_ff <= out_slot_ff;
         up_ff       <= out_row_ff != '0;
         dn_ff       <= out_row_inc < height_ff;
         lf_ff       <= out_col_ff != '0;
         rt_ff       <= out_col_inc < width_ff;
         last_ff     <= last_here;
      end
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      phase_in = PHASE_LEFT;
      case (state_ff)
         ST_IDLE: begin
            if (due) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            phase_in = phase_ff + 2'd1;
            if (phase_ff == PHASE_FLUSH) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: state_in = ST_DIV;
         ST_DIV: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready  = 1'b0;
      rd_active  = 1'b0;
      merge_load = 1'b0;
      out_load   = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_READ: begin
            case (phase_ff)
               PHASE_LEFT:   rd_active = lf_ff;
               PHASE_CENTER: rd_active = 1'b1;
               PHASE_RIGHT:  rd_active = rt_ff;
               default:      rd_active = 1'b0;
            endcase
         end
         ST_SUM: merge_load = 1'b1;
         ST_DIV: out_load = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PHASE_LEFT;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   // row lanes
   assign rd_col   = ctr_col_ff + CW'(phase_ff) - CW'(1);
   assign wr_pixel = '{red: req_ch.data.in_red, green: req_ch.data.in_green,
                       blue: req_ch.data.in_blue};

   for (genvar s = 0; s < LANES; s++) begin : g_lane
      assign lane_ctrl[s] = '{
         wr_en:   take_pixel && (in_slot_ff == 2'(s)),
         rd_en:   rd_active,
         acc_clr: accept,
         row_en:  (ctr_slot_ff == 2'(s)) ||
                  (up_ff && (prev_slot(ctr_slot_ff) == 2'(s))) ||
                  (dn_ff && (next_slot(ctr_slot_ff) == 2'(s)))
      };

      bb3_lane #(
         .MAX_WIDTH (MAX_WIDTH)
      ) u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (lane_ctrl[s]),
         .wr_addr  (in_col_ff[AW-1:0]),
         .wr_data  (wr_pixel),
         .rd_addr  (rd_col[AW-1:0]),
         .lane_sum (lane_sum[s])
      );
   end

   bb3_merge u_merge (
      .clock      (clock),
      .load       (merge_load),
      .lane_sum   (lane_sum),
      .count      (tap_count(up_ff, dn_ff, lf_ff, rt_ff)),
      .mean_red   (mean_red),
      .mean_green (mean_green),
      .mean_blue  (mean_blue)
   );

   // output register
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      rsp_data_in = '{out_red: mean_red, out_green: mean_green, out_blue: mean_blue,
                      frame_last: last_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

endmodule

// ===== src/bb3_checker.sv =====
// ----------------------------------------------------------------------------
// bb3_checker
// Port-level checks of the box blur, bound to the top level.
// ----------------------------------------------------------------------------
module bb3_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input bb3_pkg::rsp_payload_type rsp_data
);

   localparam int RESULT_LATENCY = 7;

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("stalled response dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("stalled response changed");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, RESULT_LATENCY))
      else $error("response without request at fixed latency");

endmodule

bind box_blur_3x3 bb3_checker u_bb3_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_data  (rsp_ch.data)
);

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 3x3 box blur. A driver and a monitor run as
// clocked processes on the valid/ready channels; every accepted request is
// fed to a line-buffer predictor kept in the bench, whose blurred pixels are
// checked field by field, in order, against the result channel. Frame size is
// swept through reset values, clamped extremes and random small sizes under
// several handshake paces, with one long result stall.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bb3_pkg::*;

   localparam int PAW = $clog2(MAX_WIDTH_DEF);

   typedef enum {
      PACE_FULL,
      PACE_SRC_IDLE,
      PACE_SNK_STALL,
      PACE_BOTH
   } pace_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   bb3_stream_if #(.payload_type(req_payload_type)) req_ch ();
   bb3_stream_if #(.payload_type(rsp_payload_type)) rsp_ch ();

   box_blur_3x3 i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // blur predictor state
   pixel_type   row_mem [3][MAX_WIDTH_DEF];
   int unsigned cfg_width  = FRAME_WIDTH_RST;
   int unsigned cfg_height = FRAME_HEIGHT_RST;
   int unsigned in_col, in_row, out_col, out_row;

   req_payload_type pending_req [$];
   rsp_payload_type expected_px [$];

   int gap_pct   = 0;
   int stall_pct = 0;
   int rsp_hold  = 0;

   int unsigned errors       = 0;
   int unsigned queued_cnt   = 0;
   int unsigned accepted_cnt = 0;
   int unsigned checked_cnt  = 0;
   int unsigned size_cnt     = 0;

   always #1 clock = ~clock;

   function automatic int unsigned frame_dim(input int unsigned v, input int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void restart_blur_frame();
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
   endfunction

   task automatic blur_predict(input req_payload_type rq);
      int unsigned w, h, nr, nc, need, got, cnt;
      int unsigned sum_r, sum_g, sum_b;
      int rr, cc;
      bit inputs_done;
      pixel_type p;
      rsp_payload_type o;
      w = frame_dim(cfg_width, MAX_WIDTH_DEF);
      h = frame_dim(cfg_height, MAX_HEIGHT_DEF);
      inputs_done = (in_row >= h);
      if (rq.req_type == REQ_PIXEL) begin
         if (inputs_done) return;
         row_mem[2'(in_row % 3)][PAW'(in_col)] = {rq.in_red, rq.in_green, rq.in_blue};
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
         end
      end else if (!inputs_done) begin
         return;
      end
      if (out_row >= h) return;
      // wait for the last neighbor in raster order
      nr = (out_row + 1 < h) ? out_row + 1 : h - 1;
      nc = (out_col + 1 < w) ? out_col + 1 : w - 1;
      need = nr * w + nc;
      got = (in_row >= h) ? h * w : in_row * w + in_col;
      if (got <= need) return;
      cnt   = 0;
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      for (int dr = -1; dr <= 1; dr++) begin
         for (int dc = -1; dc <= 1; dc++) begin
            rr = int'(out_row) + dr;
            cc = int'(out_col) + dc;
            if (rr >= 0 && cc >= 0 && rr < int'(h) && cc < int'(w)) begin
               p = row_mem[2'(rr % 3)][PAW'(cc)];
               sum_r += 32'(p.red);
               sum_g += 32'(p.green);
               sum_b += 32'(p.blue);
               cnt++;
            end
         end
      end
      o.out_red    = 8'((2 * sum_r + cnt) / (2 * cnt));
      o.out_green  = 8'((2 * sum_g + cnt) / (2 * cnt));
      o.out_blue   = 8'((2 * sum_b + cnt) / (2 * cnt));
      o.frame_last = (out_row == h - 1) && (out_col == w - 1);
      expected_px.push_back(o);
      if (o.frame_last) begin
         restart_blur_frame();
      end else begin
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
         end
      end
   endtask

   function automatic void check_field(input string name, input int unsigned exp_v,
                                       input int unsigned act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s expected %0d got %0d", $time, name, exp_v, act_v);
         errors++;
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.data  <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            blur_predict(pending_req.pop_front());
            accepted_cnt++;
         end
         if (!(req_ch.valid && !req_ch.ready)) begin
            if (pending_req.size() > 0 && (gap_pct == 0 || $urandom_range(99) >= gap_pct))
            begin
               req_ch.valid <= 1'b1;
               req_ch.data  <= pending_req[0];
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // result receiver with an optional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_hold     <= rsp_hold - 1;
      end else begin
         rsp_ch.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
      end
   end

   // result monitor
   always @(posedge clock) begin : rsp_monitor
      rsp_payload_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_px.size() == 0) begin
            $display("%0t: unexpected pixel expected none got %h", $time, rsp_ch.data);
            errors++;
         end else begin
            want = expected_px.pop_front();
            check_field("out_red", 32'(want.out_red), 32'(rsp_ch.data.out_red));
            check_field("out_green", 32'(want.out_green), 32'(rsp_ch.data.out_green));
            check_field("out_blue", 32'(want.out_blue), 32'(rsp_ch.data.out_blue));
            check_field("frame_last", 32'(want.frame_last), 32'(rsp_ch.data.frame_last));
            checked_cnt++;
         end
      end
   end

   function automatic logic [7:0] rand_chan();
      case ($urandom_range(5))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic req_payload_type px(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
      return {REQ_PIXEL, r, g, b};
   endfunction

   function automatic req_payload_type drain_req();
      return {REQ_DRAIN, rand_chan(), rand_chan(), rand_chan()};
   endfunction

   task automatic queue_req(input req_payload_type rq);
      pending_req.push_back(rq);
      queued_cnt++;
   endtask

   task automatic push_frame(input int unsigned w, input int unsigned h, input bit noisy);
      int unsigned n_drain;
      for (int unsigned i = 0; i < w * h; i++) begin
         if (noisy && $urandom_range(29) == 0) queue_req(drain_req());
         queue_req(px(rand_chan(), rand_chan(), rand_chan()));
      end
      if (noisy && $urandom_range(9) == 0) queue_req(px(rand_chan(), rand_chan(), rand_chan()));
      n_drain = noisy ? w + $urandom_range(2) : w;
      // broken tail: too few drains leave the frame open
      if (noisy && $urandom_range(19) == 0) n_drain = $urandom_range(w);
      repeat (n_drain) queue_req(drain_req());
   endtask

   task automatic wait_drained();
      while (pending_req.size() != 0 || req_ch.valid || expected_px.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx, input int unsigned value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_BITS'(value);
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_FRAME_WIDTH)
         cfg_width = value % (1 << WIDTH_REG_BITS);
      else
         cfg_height = value % (1 << HEIGHT_REG_BITS);
      restart_blur_frame();
   endtask

   task automatic set_size(input int unsigned w, input int unsigned h);
      write_reg(CSR_FRAME_WIDTH, w);
      write_reg(CSR_FRAME_HEIGHT, h);
      size_cnt++;
   endtask

   task automatic set_pace(input pace_type pace);
      @(posedge clock);
      case (pace)
         PACE_FULL: begin
            gap_pct   <= 0;
            stall_pct <= 0;
         end
         PACE_SRC_IDLE: begin
            gap_pct   <= 80;
            stall_pct <= 0;
         end
         PACE_SNK_STALL: begin
            gap_pct   <= 0;
            stall_pct <= 80;
         end
         default: begin
            gap_pct   <= 12;
            stall_pct <= 12;
         end
      endcase
   endtask

   int unsigned ext_w [5] = '{0, 5, 1, 4095, 1};
   int unsigned ext_h [5] = '{3, 0, 1, 1, 8191};

   initial begin
      int unsigned start_cnt, w, h;
      pace_type pace;
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      rsp_ch.ready = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset frame size: a partial first row leaves nothing due
      set_pace(PACE_FULL);
      repeat (24) queue_req(px(rand_chan(), rand_chan(), rand_chan()));
      wait_drained();

      // directed 3x3 frame with ignored drains and pixels
      set_size(3, 3);
      queue_req(drain_req());
      queue_req(px(8'h00, 8'h00, 8'h00));
      queue_req(px(8'hFF, 8'hFF, 8'hFF));
      queue_req(px(8'hFF, 8'h00, 8'h80));
      queue_req(px(8'h01, 8'h02, 8'h03));
      queue_req(drain_req());
      queue_req(px(8'hFF, 8'hFF, 8'hFF));
      queue_req(px(8'h00, 8'hFF, 8'h00));
      queue_req(px(8'hFE, 8'h01, 8'h7F));
      queue_req(px(8'h00, 8'h00, 8'hFF));
      queue_req(px(8'hFF, 8'hFF, 8'hFF));
      queue_req(px(8'h55, 8'hAA, 8'h55));
      repeat (5) queue_req(drain_req());
      queue_req(px(8'hAA, 8'h55, 8'hAA));
      wait_drained();

      // clamped and degenerate sizes, large ones as partial frames
      foreach (ext_w[i]) begin
         set_size(ext_w[i], ext_h[i]);
         w = frame_dim(ext_w[i], MAX_WIDTH_DEF);
         h = frame_dim(ext_h[i], MAX_HEIGHT_DEF);
         if (w * h <= 64)
            push_frame(w, h, 0);
         else
            repeat (40) queue_req(px(rand_chan(), rand_chan(), rand_chan()));
         wait_drained();
      end

      // long result stall while requests keep coming
      set_size(8, 6);
      @(posedge clock);
      rsp_hold <= 300;
      push_frame(8, 6, 0);
      wait_drained();

      // random frames under each pace
      for (int m = 0; m < 4; m++) begin
         pace = pace_type'(m);
         set_pace(pace);
         start_cnt = queued_cnt;
         while (queued_cnt - start_cnt < 40) begin
            w = ($urandom_range(3) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 9);
            h = (w > 9) ? $urandom_range(1, 2) : $urandom_range(1, 6);
            set_size(w, h);
            repeat ($urandom_range(1, 3)) push_frame(w, h, 1);
            wait_drained();
         end
      end

      $display("summary: %0d requests accepted, %0d blurred pixels checked", accepted_cnt,
               checked_cnt);
      $display("summary: %0d frame sizes incl. clamped extremes, four handshake paces",
               size_cnt);
      if (errors == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

   initial begin
      #400_000;
      $display("tb: errors");
      $finish;
   end

endmodule
